/* hw/rtl/hsvx_pkg.sv */
// ============================================================================
// HSV color exchange package
// Shared word types, configuration register indexes, converter states and
// small color helper functions.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package hsvx_pkg;

  localparam int CFG_DATA_W = 24;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_MASK_PRESENT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_VALIDATE_MASK = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BASE_RGB      = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPL_COLOR    = 2'd3;

  localparam logic [6:0] SAT_MAX = 7'd100;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
    logic [7:0] mask_red;
    logic [7:0] mask_green;
    logic [7:0] mask_blue;
    logic [7:0] mask_alpha;
  } hsvx_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       mask_error;
  } hsvx_out_t;

  // Recolor parameters derived from the base and replacement colors.
  typedef struct packed {
    logic [6:0]        base_sat;
    logic signed [7:0] sat_delta;
    logic signed [7:0] val_delta;
    logic [2:0]        sector;
    logic [5:0]        frac;
  } hsvx_params_t;

  typedef enum logic [2:0] {
    CV_IDLE,
    CV_LOAD,
    CV_BASE_SAT,
    CV_REPL_SAT,
    CV_REPL_HUE
  } hsvx_cv_state_t;

  function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    logic [7:0] m;
    m = a;
    if (b > m) m = b;
    if (c > m) m = c;
    return m;
  endfunction

  function automatic logic [7:0] min3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    logic [7:0] m;
    m = a;
    if (b < m) m = b;
    if (c < m) m = c;
    return m;
  endfunction

  // floor(100 * mx / 255) by the exact add-and-shift form of a divide by 255.
  function automatic logic [6:0] value_of(input logic [7:0] mx);
    logic [14:0] x;
    logic [15:0] t;
    x = 15'(mx) * 15'd100;
    t = 16'(x) + 16'd1 + 16'(x >> 8);
    return t[14:8];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/hsv_color_exchange_pixel.sv */
// ============================================================================
// HSV color exchange pixel recolor
// Recolors one RGBA pixel per word: selected pixels take the replacement hue
// and have saturation and value shifted by replacement minus base.
// ============================================================================
// Throughput: one word per cycle through the eight-stage pipe while out_ready
// is high and neither a configuration write nor the converter holds input.
// After each configuration write the parameter converter runs, one divider
// quotient bit per cycle, and in_ready is low while it runs.
// Reset is synchronous, active low: valids, config and params clear, data not.
`timescale 1ns / 1ps
`default_nettype none

module hsv_color_exchange_pixel (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  hsvx_pkg::hsvx_in_t                     in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output hsvx_pkg::hsvx_out_t                    out_data,
  input  wire logic                              cfg_we,
  input  wire logic [hsvx_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [hsvx_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import hsvx_pkg::*;

  // Configuration registers. The user must let them change only while the block is idle; the block does not enforce it.
  logic        mask_present_r;
  logic        validate_mask_r;
  logic [23:0] base_rgb_r;
  logic [23:0] repl_color_r;

  hsvx_params_t params;
  logic         conv_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_present_r  <= 1'b0;
      validate_mask_r <= 1'b0;
      base_rgb_r      <= '0;
      repl_color_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MASK_PRESENT:  mask_present_r  <= cfg_wdata[0];
        CFG_VALIDATE_MASK: validate_mask_r <= cfg_wdata[0];
        CFG_BASE_RGB:      base_rgb_r      <= cfg_wdata[23:0];
        CFG_REPL_COLOR:    repl_color_r    <= cfg_wdata[23:0];
        default: begin
        end
      endcase
    end
  end

  // The converter recomputes base saturation, the saturation and value deltas,
  // the replacement hue sector and fraction after every write. Those values
  // stay fixed while pixels stream, so the pipe reads them directly.
  hsvx_conv u_conv (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .base_rgb   (base_rgb_r),
    .repl_color (repl_color_r),
    .params     (params),
    .busy       (conv_busy)
  );

  // The pipe holds off new words while the converter runs. Its ready chain
  // runs from out_ready back to in_ready, and each stage moves as soon as the
  // next one has room, so bubbles close up while a result waits downstream.
  hsvx_pipe u_pipe (
    .clk           (clk),
    .rst_n         (rst_n),
    .hold          (conv_busy || cfg_we),
    .mask_present  (mask_present_r),
    .validate_mask (validate_mask_r),
    .params        (params),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data)
  );

endmodule

`default_nettype wire

/* hw/rtl/hsvx_conv.sv */
// ============================================================================
// HSV color exchange parameter converter
// Turns the base and replacement colors into saturation, value and hue terms
// with one shared restoring divider, one quotient bit per cycle.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module hsvx_conv (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [23:0]            base_rgb,
  input  wire logic [23:0]            repl_color,
  output hsvx_pkg::hsvx_params_t      params,
  output logic                        busy
);
  import hsvx_pkg::*;

  hsvx_cv_state_t state_r, state_nxt;
  hsvx_params_t   params_r, params_nxt;
  logic [16:0]    rem_r, rem_nxt;
  logic [7:0]     div_r, div_nxt;
  logic [3:0]     cnt_r, cnt_nxt;
  logic [8:0]     q_r, q_nxt;

  logic [7:0]  br, bg, bb, rr, rg, rb;
  logic [7:0]  bmx, bd, rmx, rd;
  logic [6:0]  bv, rv;
  logic [16:0] hue_num;
  logic [16:0] dsh;
  logic        take;
  logic [16:0] rem_step;
  logic [8:0]  q_step;
  logic [2:0]  sec;
  logic [8:0]  frac_full;

  assign br = base_rgb[23:16];
  assign bg = base_rgb[15:8];
  assign bb = base_rgb[7:0];
  assign rr = repl_color[23:16];
  assign rg = repl_color[15:8];
  assign rb = repl_color[7:0];

  assign bmx = max3(br, bg, bb);
  assign bd  = bmx - min3(br, bg, bb);
  assign rmx = max3(rr, rg, rb);
  assign rd  = rmx - min3(rr, rg, rb);
  assign bv  = value_of(bmx);
  assign rv  = value_of(rmx);

  // Hue numerator; red wins ties over green, green over blue.
  always_comb begin
    if (rr >= rmx) begin
      if (rg >= rb) hue_num = 17'd60 * 17'(rg - rb);
      else          hue_num = 17'd360 * 17'(rd) - 17'd60 * 17'(rb - rg);
    end else if (rg >= rmx) begin
      hue_num = 17'd120 * 17'(rd) + 17'd60 * 17'(rb) - 17'd60 * 17'(rr);
    end else begin
      hue_num = 17'd240 * 17'(rd) + 17'd60 * 17'(rr) - 17'd60 * 17'(rg);
    end
  end

  assign dsh      = 17'(div_r) << cnt_r;
  assign take     = (div_r != 8'd0) && (rem_r >= dsh);
  assign rem_step = take ? rem_r - dsh : rem_r;
  assign q_step   = q_r | (take ? (9'd1 << cnt_r) : 9'd0);

  always_comb begin
    if (q_step >= 9'd300)      sec = 3'd5;
    else if (q_step >= 9'd240) sec = 3'd4;
    else if (q_step >= 9'd180) sec = 3'd3;
    else if (q_step >= 9'd120) sec = 3'd2;
    else if (q_step >= 9'd60)  sec = 3'd1;
    else                       sec = 3'd0;
  end
  assign frac_full = q_step - 9'(sec) * 9'd60;

  always_comb begin
    state_nxt  = state_r;
    params_nxt = params_r;
    rem_nxt    = rem_r;
    div_nxt    = div_r;
    cnt_nxt    = cnt_r;
    q_nxt      = q_r;
    case (state_r)
      CV_IDLE: begin
      end
      CV_LOAD: begin
        params_nxt.val_delta = $signed({1'b0, rv}) - $signed({1'b0, bv});
        rem_nxt   = 17'd100 * 17'(bd);
        div_nxt   = bmx;
        cnt_nxt   = 4'd6;
        q_nxt     = '0;
        state_nxt = CV_BASE_SAT;
      end
      CV_BASE_SAT: begin
        rem_nxt = rem_step;
        q_nxt   = q_step;
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          params_nxt.base_sat = q_step[6:0];
          rem_nxt   = 17'd100 * 17'(rd);
          div_nxt   = rmx;
          cnt_nxt   = 4'd6;
          q_nxt     = '0;
          state_nxt = CV_REPL_SAT;
        end
      end
      CV_REPL_SAT: begin
        rem_nxt = rem_step;
        q_nxt   = q_step;
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          params_nxt.sat_delta = $signed({1'b0, q_step[6:0]})
                               - $signed({1'b0, params_r.base_sat});
          rem_nxt   = hue_num;
          div_nxt   = rd;
          cnt_nxt   = 4'd8;
          q_nxt     = '0;
          state_nxt = CV_REPL_HUE;
        end
      end
      CV_REPL_HUE: begin
        rem_nxt = rem_step;
        q_nxt   = q_step;
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          params_nxt.sector = sec;
          params_nxt.frac   = frac_full[5:0];
          state_nxt         = CV_IDLE;
        end
      end
      default: begin
        state_nxt = CV_IDLE;
      end
    endcase
    if (cfg_we) state_nxt = CV_LOAD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= CV_IDLE;
      params_r <= '0;
    end else begin
      state_r  <= state_nxt;
      params_r <= params_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
  end

  assign params = params_r;
  assign busy   = (state_r != CV_IDLE);

`ifndef SYNTHESIS
  a_write_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (state_r == CV_LOAD))
    else $error("config write did not restart the converter");

  a_hue_terms: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == CV_REPL_HUE && cnt_r == 4'd0 && !cfg_we) |=>
      (params_r.frac < 6'd60 && params_r.sector < 3'd6 && state_r == CV_IDLE))
    else $error("hue sector or fraction out of range");

  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == CV_BASE_SAT || state_r == CV_REPL_SAT) |-> (q_r <= 9'd100))
    else $error("saturation quotient above 100");
`endif

endmodule

`default_nettype wire

/* hw/rtl/hsvx_pipe.sv */
// ============================================================================
// HSV color exchange pixel pipeline
// Eight register stages: analysis, two saturation divide stages, adjust,
// channel terms, products, scaling and final rounding with sector select.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module hsvx_pipe (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   hold,
  input  wire logic                   mask_present,
  input  wire logic                   validate_mask,
  input  hsvx_pkg::hsvx_params_t      params,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  hsvx_pkg::hsvx_in_t          in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output hsvx_pkg::hsvx_out_t         out_data
);
  import hsvx_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       sel;
    logic       err;
  } pass_t;

  localparam int NCH = 4;   // x, y, z and full-value channel terms

  logic [8:1] vld_r;
  logic [8:1] en;

  pass_t pass1_r, pass2_r, pass3_r, pass4_r, pass5_r, pass6_r, pass7_r;
  pass_t pass1_nxt;
  logic [7:0]  mx1_r, d1_r, mx2_r;
  logic [6:0]  v2_r, v3_r, v4_r, v5_r;
  logic [14:0] rem2_r;
  logic [6:0]  q2_r, sat3_r, sat4_r;
  logic [12:0] k5_r [NCH-1:0];
  logic [19:0] prod6_r [NCH-1:0];
  logic [17:0] y7_r [NCH-1:0];
  logic [8:0]  q07_r [NCH-1:0];
  hsvx_out_t   out_r, out_nxt;

  logic [14:0] rem2_nxt, rem3_a, dsh_a, dsh_b;
  logic [6:0]  q2_nxt, q3_a;
  logic [6:0]  sat4_nxt, v4_nxt;
  logic [12:0] k5_nxt [NCH-1:0];
  logic [19:0] prod6_nxt [NCH-1:0];
  logic [17:0] y7_nxt [NCH-1:0];
  logic [8:0]  q07_nxt [NCH-1:0];
  logic [7:0]  ch8 [NCH-1:0];
  logic [17:0] res8 [NCH-1:0];

  // Ready chain: a stage loads when it is empty or its successor moves.
  assign en[8] = !vld_r[8] || out_ready;
  genvar gs;
  generate
    for (gs = 1; gs < 8; gs++) begin : g_en
      assign en[gs] = !vld_r[gs] || en[gs+1];
    end
  endgenerate

  assign in_ready = en[1] && !hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[1]) vld_r[1] <= in_valid && !hold;
      for (int i = 2; i <= 8; i++) begin
        if (en[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // Stage 1: mask decode and channel extremes.
  always_comb begin
    logic red, white;
    red   = (in_data.mask_red == 8'hFF) && (in_data.mask_green == 8'h00) &&
            (in_data.mask_blue == 8'h00) && (in_data.mask_alpha == 8'hFF);
    white = (in_data.mask_red == 8'hFF) && (in_data.mask_green == 8'hFF) &&
            (in_data.mask_blue == 8'hFF) && (in_data.mask_alpha == 8'hFF);
    pass1_nxt.red   = in_data.in_red;
    pass1_nxt.green = in_data.in_green;
    pass1_nxt.blue  = in_data.in_blue;
    pass1_nxt.alpha = in_data.in_alpha;
    pass1_nxt.sel   = 1'b1;
    pass1_nxt.err   = 1'b0;
    if (mask_present) begin
      pass1_nxt.sel = red;
      if (validate_mask && !red && !white && (in_data.mask_alpha != 8'h00)) begin
        pass1_nxt.err = 1'b1;
      end
    end
  end

  // Stage 2: value and the upper four saturation quotient bits.
  always_comb begin
    rem2_nxt = 15'(d1_r) * 15'd100;
    q2_nxt   = '0;
    for (int i = 6; i >= 3; i--) begin
      dsh_a = 15'(mx1_r) << i;
      if (mx1_r != 8'd0 && rem2_nxt >= dsh_a) begin
        rem2_nxt  = rem2_nxt - dsh_a;
        q2_nxt[i] = 1'b1;
      end
    end
  end

  // Stage 3: the lower three quotient bits.
  always_comb begin
    rem3_a = rem2_r;
    q3_a   = q2_r;
    for (int i = 2; i >= 0; i--) begin
      dsh_b = 15'(mx2_r) << i;
      if (mx2_r != 8'd0 && rem3_a >= dsh_b) begin
        rem3_a  = rem3_a - dsh_b;
        q3_a[i] = 1'b1;
      end
    end
  end

  // Stage 4: grey pixels take the base saturation, then shift and clamp.
  always_comb begin
    logic [6:0]        s0;
    logic signed [8:0] st, vt;
    s0 = (sat3_r == 7'd0) ? params.base_sat : sat3_r;
    st = $signed({2'b00, s0}) + $signed({params.sat_delta[7], params.sat_delta});
    vt = $signed({2'b00, v3_r}) + $signed({params.val_delta[7], params.val_delta});
    if (st < 0)                           sat4_nxt = 7'd0;
    else if (st > $signed({2'b00, SAT_MAX})) sat4_nxt = SAT_MAX;
    else                                  sat4_nxt = st[6:0];
    if (vt < 0)                           v4_nxt = 7'd0;
    else if (vt > $signed({2'b00, SAT_MAX})) v4_nxt = SAT_MAX;
    else                                  v4_nxt = vt[6:0];
  end

  // Stage 5: channel weights for the replacement hue sector.
  always_comb begin
    k5_nxt[0] = 13'd60 * 13'(SAT_MAX - sat4_r);
    k5_nxt[1] = 13'd6000 - 13'(sat4_r) * 13'(params.frac);
    k5_nxt[2] = 13'd6000 - 13'(sat4_r) * 13'(6'd60 - params.frac);
    k5_nxt[3] = 13'd6000;
  end

  // Stages 6 and 7: value times weight, then the divide by 40000 estimate.
  // The reciprocal of 625 is rounded down, so the estimate is never high and
  // falls short by at most one.
  always_comb begin
    logic [23:0] x;
    logic [30:0] m;
    for (int c = 0; c < NCH; c++) begin
      prod6_nxt[c] = 20'(v5_r) * 20'(k5_r[c]);
      x            = 24'(prod6_r[c]) * 24'd17 + 24'd20000;
      y7_nxt[c]    = x[23:6];
      m            = 31'(y7_nxt[c]) * 31'd6710;
      q07_nxt[c]   = m[30:22];
    end
  end

  // Stage 8: one correction step and the sector mapping.
  always_comb begin
    logic [8:0] qf;
    for (int c = 0; c < NCH; c++) begin
      res8[c] = y7_r[c] - 18'(q07_r[c]) * 18'd625;
      qf      = (res8[c] >= 18'd625) ? q07_r[c] + 9'd1 : q07_r[c];
      ch8[c]  = qf[7:0];
    end
    out_nxt.out_alpha  = pass7_r.alpha;
    out_nxt.mask_error = pass7_r.err;
    case (params.sector)
      3'd0: begin
        out_nxt.out_red = ch8[3]; out_nxt.out_green = ch8[2]; out_nxt.out_blue = ch8[0];
      end
      3'd1: begin
        out_nxt.out_red = ch8[1]; out_nxt.out_green = ch8[3]; out_nxt.out_blue = ch8[0];
      end
      3'd2: begin
        out_nxt.out_red = ch8[0]; out_nxt.out_green = ch8[3]; out_nxt.out_blue = ch8[2];
      end
      3'd3: begin
        out_nxt.out_red = ch8[0]; out_nxt.out_green = ch8[1]; out_nxt.out_blue = ch8[3];
      end
      3'd4: begin
        out_nxt.out_red = ch8[2]; out_nxt.out_green = ch8[0]; out_nxt.out_blue = ch8[3];
      end
      default: begin
        out_nxt.out_red = ch8[3]; out_nxt.out_green = ch8[0]; out_nxt.out_blue = ch8[1];
      end
    endcase
    if (!pass7_r.sel) begin
      out_nxt.out_red   = pass7_r.red;
      out_nxt.out_green = pass7_r.green;
      out_nxt.out_blue  = pass7_r.blue;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pass1_r <= pass1_nxt;
      mx1_r   <= max3(in_data.in_red, in_data.in_green, in_data.in_blue);
      d1_r    <= max3(in_data.in_red, in_data.in_green, in_data.in_blue)
               - min3(in_data.in_red, in_data.in_green, in_data.in_blue);
    end
    if (en[2]) begin
      pass2_r <= pass1_r;
      mx2_r   <= mx1_r;
      v2_r    <= value_of(mx1_r);
      rem2_r  <= rem2_nxt;
      q2_r    <= q2_nxt;
    end
    if (en[3]) begin
      pass3_r <= pass2_r;
      v3_r    <= v2_r;
      sat3_r  <= q3_a;
    end
    if (en[4]) begin
      pass4_r <= pass3_r;
      sat4_r  <= sat4_nxt;
      v4_r    <= v4_nxt;
    end
    if (en[5]) begin
      pass5_r <= pass4_r;
      v5_r    <= v4_r;
      k5_r    <= k5_nxt;
    end
    if (en[6]) begin
      pass6_r <= pass5_r;
      prod6_r <= prod6_nxt;
    end
    if (en[7]) begin
      pass7_r <= pass6_r;
      y7_r    <= y7_nxt;
      q07_r   <= q07_nxt;
    end
    if (en[8]) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = vld_r[8];
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_err_unselected: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[1] && pass1_r.err) |-> !pass1_r.sel)
    else $error("mask error on a selected pixel");

  a_adjust_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[4] |-> (sat4_r <= SAT_MAX && v4_r <= SAT_MAX))
    else $error("adjusted saturation or value out of range");

  a_estimate_close: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[7] |-> (res8[0] < 18'd1250 && res8[1] < 18'd1250 &&
                  res8[2] < 18'd1250 && res8[3] < 18'd1250))
    else $error("scaling estimate off by more than one");
`endif

endmodule

`default_nettype wire

/* tb/tb_hsv_color_exchange_pixel.sv */
// ============================================================================
// HSV color exchange pixel recolor testbench
// Drives pixel and mask words through the recolor block, predicts every
// result with an independent integer HSV model and checks each output word
// in order, across several base and replacement color settings.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tb_hsv_color_exchange_pixel;
  import hsvx_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  hsvx_in_t   in_data;
  logic       out_valid;
  logic       out_ready;
  hsvx_out_t  out_data;
  logic       cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  hsv_color_exchange_pixel u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the configuration registers, used by the predictor.
  logic        sh_mask_present;
  logic        sh_validate;
  logic [23:0] sh_base;
  logic [23:0] sh_repl;

  hsvx_out_t pixels_expected[$];
  int        fail_count;
  int        idle_cycles;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        words_sent;
  int        words_checked;
  int        masked_words;
  int        error_words;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Integer RGB to HSV conversion, truncating as the block does.
  task automatic rgb_to_hsv(input int r, input int g, input int b,
                            output int h, output int s, output int v);
    int mx;
    int mn;
    int d;
    int num;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    v = (100 * mx) / 255;
    s = (mx > 0) ? (100 * d) / mx : 0;
    if (d == 0) begin
      h = 0;
    end else begin
      if (r >= mx) begin
        num = (g >= b) ? 60 * (g - b) : 360 * d - 60 * (b - g);
      end else if (g >= mx) begin
        num = 120 * d + 60 * b - 60 * r;
      end else begin
        num = 240 * d + 60 * r - 60 * g;
      end
      h = num / d;
      if (h > 359) h = 359;
    end
  endtask

  function automatic int channel_level(input int v, input int k);
    longint n;
    n = 64'(255) * v * k;
    return int'((n + 300000) / 600000);
  endfunction

  task automatic hsv_to_rgb(input int h, input int s, input int v,
                            output int r, output int g, output int b);
    int f;
    int cx;
    int cy;
    int cz;
    int cv;
    if (s == 0) begin
      r = (255 * v + 50) / 100; g = r; b = r;
    end else begin
      h = h % 360;
      f = h % 60;
      cx = channel_level(v, 60 * (100 - s));
      cy = channel_level(v, 6000 - s * f);
      cz = channel_level(v, 6000 - s * (60 - f));
      cv = channel_level(v, 6000);
      case (h / 60)
        0: begin r = cv; g = cz; b = cx; end
        1: begin r = cy; g = cv; b = cx; end
        2: begin r = cx; g = cv; b = cz; end
        3: begin r = cx; g = cy; b = cv; end
        4: begin r = cz; g = cx; b = cv; end
        default: begin r = cv; g = cx; b = cy; end
      endcase
    end
  endtask

  function automatic int clamp_percent(input int x);
    if (x < 0) return 0;
    if (x > 100) return 100;
    return x;
  endfunction

  // Works out the recolored word for one input word under the shadow settings.
  task automatic predict_recolor(input hsvx_in_t px, output hsvx_out_t res);
    logic selected;
    logic is_red;
    logic is_white;
    int bh, bs, bv, rh, rs, rv, h, s, v, r, g, b;
    selected = 1'b1;
    res.mask_error = 1'b0;
    is_red = px.mask_red == 8'hFF && px.mask_green == 8'h00 &&
             px.mask_blue == 8'h00 && px.mask_alpha == 8'hFF;
    is_white = px.mask_red == 8'hFF && px.mask_green == 8'hFF &&
               px.mask_blue == 8'hFF && px.mask_alpha == 8'hFF;
    if (sh_mask_present) begin
      selected = is_red;
      if (sh_validate && !is_red && !is_white && px.mask_alpha != 8'h00)
        res.mask_error = 1'b1;
    end
    res.out_red = px.in_red;
    res.out_green = px.in_green;
    res.out_blue = px.in_blue;
    res.out_alpha = px.in_alpha;
    if (selected) begin
      rgb_to_hsv(sh_base[23:16], sh_base[15:8], sh_base[7:0], bh, bs, bv);
      rgb_to_hsv(sh_repl[23:16], sh_repl[15:8], sh_repl[7:0], rh, rs, rv);
      rgb_to_hsv(px.in_red, px.in_green, px.in_blue, h, s, v);
      if (s == 0) s = bs;
      s = clamp_percent(s + rs - bs);
      v = clamp_percent(v + rv - bv);
      hsv_to_rgb(rh, s, v, r, g, b);
      res.out_red = r[7:0];
      res.out_green = g[7:0];
      res.out_blue = b[7:0];
    end
  endtask

  // Receiver: random stalls and an in-order check of every accepted word.
  always @(posedge clk) begin
    hsvx_out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pixels_expected.size() == 0) begin
          $error("unexpected output word %h", out_data);
          fail_count++;
        end else begin
          want = pixels_expected.pop_front();
          words_checked++;
          if (out_data.out_red !== want.out_red) begin
            $error("out_red expected %0d actual %0d", want.out_red, out_data.out_red);
            fail_count++;
          end
          if (out_data.out_green !== want.out_green) begin
            $error("out_green expected %0d actual %0d", want.out_green, out_data.out_green);
            fail_count++;
          end
          if (out_data.out_blue !== want.out_blue) begin
            $error("out_blue expected %0d actual %0d", want.out_blue, out_data.out_blue);
            fail_count++;
          end
          if (out_data.out_alpha !== want.out_alpha) begin
            $error("out_alpha expected %0d actual %0d", want.out_alpha, out_data.out_alpha);
            fail_count++;
          end
          if (out_data.mask_error !== want.mask_error) begin
            $error("mask_error expected %0d actual %0d", want.mask_error,
                   out_data.mask_error);
            fail_count++;
          end
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: counts cycles in which neither channel accepts a word. The
  // converter pass after a write and long stalls sit far below its limit.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Sends one word; the expectation is queued at the accepting edge, using the
  // settings that are in force then. Valid stays high between back-to-back
  // words and drops only when the sender idles.
  task automatic send_pixel(input hsvx_in_t px);
    hsvx_out_t res;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_recolor(px, res);
    pixels_expected.push_back(res);
    words_sent++;
    if (sh_mask_present) masked_words++;
    if (res.mask_error) error_words++;
  endtask

  // Waits for all outstanding words, then lets the pipe drain fully.
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (pixels_expected.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_MASK_PRESENT:  sh_mask_present = val[0];
      CFG_VALIDATE_MASK: sh_validate = val[0];
      CFG_BASE_RGB:      sh_base = val;
      default:           sh_repl = val;
    endcase
  endtask

  task automatic apply_settings(input logic mp, input logic vm,
                                input logic [23:0] base, input logic [23:0] repl);
    drain_pipe();
    write_register(CFG_MASK_PRESENT, {23'd0, mp});
    write_register(CFG_VALIDATE_MASK, {23'd0, vm});
    write_register(CFG_BASE_RGB, base);
    write_register(CFG_REPL_COLOR, repl);
    cfg_we <= 1'b0;
  endtask

  function automatic hsvx_in_t make_pixel(input logic [31:0] rgba,
                                          input logic [31:0] mask);
    hsvx_in_t px;
    {px.in_red, px.in_green, px.in_blue, px.in_alpha} = rgba;
    {px.mask_red, px.mask_green, px.mask_blue, px.mask_alpha} = mask;
    return px;
  endfunction

  // Half the mask words are the meaningful colors, the rest random noise.
  function automatic logic [31:0] random_mask();
    case ($urandom_range(5))
      0, 1: return 32'hFF0000FF;
      2:    return 32'hFFFFFFFF;
      3:    return {24'($urandom()), 8'h00};
      4:    return {24'hFF0000, 8'($urandom_range(1, 254))};
      default: return $urandom();
    endcase
  endfunction

  task automatic test_channel_extremes();
    apply_settings(1'b0, 1'b0, 24'hFF0000, 24'h00FF00);
    send_pixel(make_pixel(32'h00000000, 32'h0));
    send_pixel(make_pixel(32'hFFFFFFFF, 32'hFFFFFFFF));
    send_pixel(make_pixel(32'hFF000080, 32'h0));
    send_pixel(make_pixel(32'h00FF0001, 32'h0));
    send_pixel(make_pixel(32'h0000FFFE, 32'h0));
    send_pixel(make_pixel(32'h808080AA, 32'h0));
    send_pixel(make_pixel(32'hFFFF0055, 32'h0));
    send_pixel(make_pixel(32'hFF00FF10, 32'h0));
    send_pixel(make_pixel(32'h00FFFF20, 32'h0));
  endtask

  task automatic test_mask_cases();
    apply_settings(1'b1, 1'b0, 24'h123456, 24'hFEDCBA);
    send_pixel(make_pixel(32'h4080C0FF, 32'hFF0000FF));
    send_pixel(make_pixel(32'h4080C0FF, 32'hFFFFFFFF));
    send_pixel(make_pixel(32'h4080C0FF, 32'h12345678));
    apply_settings(1'b1, 1'b1, 24'h00FF00, 24'hFF00FF);
    send_pixel(make_pixel(32'hC08040FF, 32'hFF0000FF));
    send_pixel(make_pixel(32'hC08040FF, 32'hFFFFFFFF));
    send_pixel(make_pixel(32'hC08040FF, 32'h12345600));
    send_pixel(make_pixel(32'hC08040FF, 32'hFF0000FE));
    send_pixel(make_pixel(32'hC08040FF, 32'hFFFFFF01));
    send_pixel(make_pixel(32'hC08040FF, 32'h00000080));
  endtask

  task automatic test_clamp_and_grey();
    // A black base and white replacement push value to its top clamp, a white
    // base and black replacement to the bottom; grey pixels take base saturation.
    apply_settings(1'b0, 1'b1, 24'h000000, 24'hFFFFFF);
    send_pixel(make_pixel(32'h7F7F7F00, 32'h0));
    send_pixel(make_pixel(32'h10204030, 32'h0));
    apply_settings(1'b0, 1'b0, 24'hFFFFFF, 24'h000000);
    send_pixel(make_pixel(32'hFFFFFF00, 32'h0));
    send_pixel(make_pixel(32'hFF8000FF, 32'h0));
    apply_settings(1'b0, 1'b0, 24'h808080, 24'h0000FF);
    send_pixel(make_pixel(32'h404040C0, 32'h0));
  endtask

  task automatic test_random_stream(input int count);
    logic [31:0] mask;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        apply_settings(1'($urandom_range(1)), 1'($urandom_range(1)),
                       ($urandom_range(3) == 0) ? {3{8'($urandom_range(1) * 255)}}
                                                : 24'($urandom()),
                       ($urandom_range(3) == 0) ? 24'hFFFFFF : 24'($urandom()));
      end
      // Sender holds off now and then until everything has come back.
      if (i % 173 == 50) drain_pipe();
      mask = random_mask();
      send_pixel(make_pixel($urandom(), mask));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    sh_mask_present = 1'b0;
    sh_validate = 1'b0;
    sh_base = '0;
    sh_repl = '0;
    fail_count = 0;
    idle_cycles = 0;
    words_sent = 0;
    words_checked = 0;
    masked_words = 0;
    error_words = 0;
    send_idle_pct = 19;
    recv_idle_pct = 55;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_channel_extremes();
    test_mask_cases();
    test_clamp_and_grey();
    test_random_stream(500);
    send_idle_pct = 55;
    recv_idle_pct = 19;
    test_random_stream(450);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_stream(450);
    drain_pipe();

    $display("Sent %0d pixel words and checked %0d; %0d under a mask, %0d with mask errors.",
             words_sent, words_checked, masked_words, error_words);
    $display("Color settings were changed between phases, extremes included.");
    if (fail_count == 0 && pixels_expected.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
